>>> src/bttr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttr_pkg
// Shared types and constants for the beam trend and peak tracker.
// ----------------------------------------------------------------------------
package bttr_pkg;

  localparam int          ANGLE_BITS_DEF = 24;
  localparam int          AMP_BITS_DEF   = 16;
  localparam int          TICK_BITS      = 8;
  localparam int          HIST_DEPTH     = 9;
  localparam int          AVG_SHIFT      = 3;
  localparam logic [7:0]  PERIOD_RESET   = 8'd10;

  typedef enum logic [1:0] {
    DIR_STILL = 2'd0,
    DIR_ABOVE = 2'd1,
    DIR_BELOW = 2'd2
  } dir_t;

  typedef struct packed {
    logic clear;
    logic upd;
  } ctl_t;

endpackage

`default_nettype wire

>>> src/bttr_trend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttr_trend
// Angle history for one axis, eight-entry floor average and trend compare.
// ----------------------------------------------------------------------------
module bttr_trend #(
  parameter int ANGLE_BITS = bttr_pkg::ANGLE_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  bttr_pkg::ctl_t       ctl,
  input  wire [ANGLE_BITS-1:0] angle,
  output bttr_pkg::dir_t       dir_nxt
);

  localparam int NOLD = bttr_pkg::HIST_DEPTH - 1;
  localparam int SUMW = ANGLE_BITS + bttr_pkg::AVG_SHIFT;

  // only the entries that feed the average are kept
  logic [ANGLE_BITS-1:0] hist_r [NOLD];
  bttr_pkg::dir_t        dir_r;
  logic [SUMW-1:0]       sum;
  logic [ANGLE_BITS-1:0] avg;
  bttr_pkg::dir_t        dir_new;

  always_comb begin
    sum = '0;
    for (int k = 0; k < NOLD; k++) begin
      sum = sum + SUMW'(hist_r[k]);
    end
    avg = sum[SUMW-1:bttr_pkg::AVG_SHIFT];
    if (avg > angle) begin
      dir_new = bttr_pkg::DIR_ABOVE;
    end else if (avg < angle) begin
      dir_new = bttr_pkg::DIR_BELOW;
    end else begin
      dir_new = bttr_pkg::DIR_STILL;
    end
  end

  always_comb begin
    if (ctl.clear) begin
      dir_nxt = bttr_pkg::DIR_STILL;
    end else if (ctl.upd) begin
      dir_nxt = dir_new;
    end else begin
      dir_nxt = dir_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int k = 0; k < NOLD; k++) begin
        hist_r[k] <= '0;
      end
    end else if (ctl.upd) begin
      hist_r[0] <= angle;
      for (int k = 1; k < NOLD; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= bttr_pkg::DIR_STILL;
    end else begin
      dir_r <= dir_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/bttr_peak.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttr_peak
// Running peak amplitude, three-quarter tracking threshold and enable flag.
// ----------------------------------------------------------------------------
module bttr_peak #(
  parameter int AMP_BITS = bttr_pkg::AMP_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bttr_pkg::ctl_t      ctl,
  input  wire  [AMP_BITS-1:0] amp,
  output logic [AMP_BITS-1:0] peak_nxt,
  output logic [AMP_BITS-1:0] thr_nxt,
  output logic                en_nxt
);

  logic [AMP_BITS-1:0] peak_r;
  logic [AMP_BITS-1:0] thr_r;
  logic                en_r;
  logic [AMP_BITS+1:0] amp_x3;
  logic [AMP_BITS-1:0] thr_upd;

  always_comb begin
    amp_x3   = {2'b00, amp} + {1'b0, amp, 1'b0};
    thr_upd  = amp_x3[AMP_BITS+1:2];
    peak_nxt = peak_r;
    thr_nxt  = thr_r;
    en_nxt   = en_r;
    if (ctl.clear) begin
      peak_nxt = '0;
      thr_nxt  = '0;
      en_nxt   = 1'b0;
    end else if (ctl.upd) begin
      if (peak_r <= amp) begin
        peak_nxt = amp;
        thr_nxt  = thr_upd;
      end
      en_nxt = (amp >= thr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      thr_r  <= '0;
      en_r   <= 1'b0;
    end else begin
      peak_r <= peak_nxt;
      thr_r  <= thr_nxt;
      en_r   <= en_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/beam_trend_peak_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// beam_trend_peak_tracker
// Decimated angle trend per axis with running peak and tracking threshold.
// ----------------------------------------------------------------------------
// a result is valid once its request has passed the input register and then the result register
// throughput: 1 request per cycle while out_tready does not stall the output, one result per request
// all tracking state is updated in the cycle a request leaves the input register
// reset (rst_n low, synchronous): period 10, counter, histories, peak,
// threshold and enable flag cleared, both channels empty
module beam_trend_peak_tracker #(
  parameter int ANGLE_BITS = bttr_pkg::ANGLE_BITS_DEF,
  parameter int AMP_BITS   = bttr_pkg::AMP_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // beam_amplitude, azimuth_angle, elevation_angle
  input  wire  [((AMP_BITS+2*ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  // clear_history
  input  wire         in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // azimuth_direction, elevation_direction, peak_amplitude,
  // tracking_threshold, elevation_enable
  output logic [((2*AMP_BITS+5+7)/8)*8-1:0] out_tdata,
  // update_strobe
  output logic        out_tuser
);

  localparam int OUT_USED = 2 * AMP_BITS + 5;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
  localparam int TB       = bttr_pkg::TICK_BITS;

  logic [TB-1:0]         period_r;
  logic [TB-1:0]         count_r;
  logic [TB-1:0]         count_inc;
  logic [TB-1:0]         count_nxt;
  logic                  hit;

  logic                  in_valid_r;
  logic                  clr_r;
  logic [AMP_BITS-1:0]   amp_r;
  logic [ANGLE_BITS-1:0] az_r;
  logic [ANGLE_BITS-1:0] el_r;

  logic                  out_valid_r;
  logic                  strobe_r;
  logic [OUT_USED-1:0]   data_r;

  logic                  adv;
  bttr_pkg::ctl_t        ctl;
  bttr_pkg::dir_t        az_dir;
  bttr_pkg::dir_t        el_dir;
  logic [AMP_BITS-1:0]   peak_nxt;
  logic [AMP_BITS-1:0]   thr_nxt;
  logic                  en_nxt;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_comb begin
    count_inc = count_r + TB'(1);
    hit       = (count_inc >= period_r);
    ctl.clear = adv && clr_r;
    ctl.upd   = adv && !clr_r && hit;
    if (ctl.clear || ctl.upd) begin
      count_nxt = '0;
    end else if (adv) begin
      count_nxt = count_inc;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= bttr_pkg::PERIOD_RESET;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      count_r <= count_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      clr_r <= in_tuser;
      amp_r <= in_tdata[AMP_BITS-1:0];
      az_r  <= in_tdata[AMP_BITS+ANGLE_BITS-1:AMP_BITS];
      el_r  <= in_tdata[AMP_BITS+2*ANGLE_BITS-1:AMP_BITS+ANGLE_BITS];
    end
  end

  bttr_trend #(.ANGLE_BITS(ANGLE_BITS)) u_az (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .angle   (az_r),
    .dir_nxt (az_dir)
  );

  bttr_trend #(.ANGLE_BITS(ANGLE_BITS)) u_el (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .angle   (el_r),
    .dir_nxt (el_dir)
  );

  bttr_peak #(.AMP_BITS(AMP_BITS)) u_peak (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .amp      (amp_r),
    .peak_nxt (peak_nxt),
    .thr_nxt  (thr_nxt),
    .en_nxt   (en_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      strobe_r <= ctl.upd;
      data_r   <= {en_nxt, thr_nxt, peak_nxt, el_dir, az_dir};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = strobe_r;
  assign out_tdata  = {{(OUT_W-OUT_USED){1'b0}}, data_r};

  a_evt_count_zero : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.upd |=> (count_r == '0))
    else $error("tick counter not restarted after event");

  a_clear_peak : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (u_peak.peak_r == '0 && count_r == '0))
    else $error("clear left peak or counter set");

  a_thr_follows_peak : assert property (@(posedge clk) disable iff (!rst_n)
    $past(ctl.upd) |-> (u_peak.thr_r <= u_peak.peak_r))
    else $error("threshold above peak");

  a_adv_loads_out : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced request lost before result register");

endmodule

`default_nettype wire
